// File: rtl/stprg_pkg.sv
// ----------------------------------------------------------------------------
// stprg_pkg
// Shared widths, register indexes, reset values and control types for the
// stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package stprg_pkg;

    localparam int INTV_W    = 20;
    localparam int RAMP_W    = 20;
    localparam int SPR_W     = 16;
    localparam int REVS_W    = 16;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int PROD_W    = INTV_W + RAMP_W;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV = 2'd2;

    localparam logic [INTV_W-1:0] BASE_INTERVAL_RST = 20'd1000;
    localparam logic [RAMP_W-1:0] RAMP_STEPS_RST    = 20'd0;
    localparam logic [SPR_W-1:0]  STEPS_PER_REV_RST = 16'd200;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: rtl/stprg_div.sv
// ----------------------------------------------------------------------------
// stprg_div
// Ramp interval unit: registers base * distance, then runs a restoring
// divide by the ramp length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stprg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  stprg_pkg::t_div_ctl            i_ctl,
    input  logic [stprg_pkg::INTV_W-1:0]   i_base,
    input  logic [stprg_pkg::RAMP_W-1:0]   i_dist,
    input  logic [stprg_pkg::RAMP_W-1:0]   i_ramp,
    output stprg_pkg::t_div_sts            o_sts,
    output logic [stprg_pkg::INTV_W-1:0]   o_quot
);
    import stprg_pkg::*;

    localparam int ITER_N = INTV_W;
    localparam int CNT_BW = $clog2(ITER_N);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_LOAD = 4'b0010,
        D_ITER = 4'b0100,
        D_DONE = 4'b1000
    } t_dstate;

    t_dstate             r_state, n_state;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [RAMP_W-1:0]   r_rem, n_rem;
    logic [INTV_W-1:0]   r_quo, n_quo;
    logic [CNT_BW-1:0]   r_cnt, n_cnt;
    logic [RAMP_W:0]     w_trial;
    logic                w_ge;

    assign w_trial = {r_rem, r_quo[INTV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_ramp});

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        case (r_state)
            D_IDLE: begin
                if (i_ctl.start) begin
                    n_prod  = PROD_W'(i_base) * PROD_W'(i_dist);
                    n_state = D_LOAD;
                end
            end
            D_LOAD: begin
                n_rem   = r_prod[PROD_W-1:INTV_W];
                n_quo   = r_prod[INTV_W-1:0];
                n_cnt   = '0;
                n_state = D_ITER;
            end
            D_ITER: begin
                if (w_ge) begin
                    n_rem = RAMP_W'(w_trial - {1'b0, i_ramp});
                end else begin
                    n_rem = w_trial[RAMP_W-1:0];
                end
                n_quo = {r_quo[INTV_W-2:0], w_ge};
                n_cnt = CNT_BW'(r_cnt + 1'b1);
                if (r_cnt == CNT_BW'(ITER_N - 1)) begin
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_prod <= n_prod;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    assign o_sts.busy = (r_state != D_IDLE);
    assign o_sts.done = (r_state == D_DONE);
    assign o_quot     = r_quo;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_ITER) |-> (r_rem < i_ramp))
        else $error("partial remainder not below divisor");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == D_IDLE))
        else $error("divide started while busy");

    a_done_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_DONE) |-> $past(r_state == D_ITER))
        else $error("done without iteration");

endmodule

// File: rtl/stepper_ramp_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step pulse generator with linear ramp intervals, driven by start and
// timestamp tick requests.
// States: a start goes from idle straight to the result; a tick goes to a
// check, and a step with ramps on then to a ramp state; a ramp step then
// waits for the interval divider (multiply, load, 20 restoring iterations).
// While a request is in progress no new one is taken.
// A new request is taken the cycle after the result is taken.
// Reset (synchronous, active low) restores register defaults and clears
// step count, target and last step time.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stprg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stprg_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic [stprg_pkg::TIME_W-1:0]      i_now_us,
    input  logic [stprg_pkg::REVS_W-1:0]      i_revolutions,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_step_pulse,
    output logic                              o_moving,
    output logic [stprg_pkg::CNT_W-1:0]       o_position
);
    import stprg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_RAMP  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [INTV_W-1:0]  r_base, n_base;
    logic [RAMP_W-1:0]  r_ramp, n_ramp;
    logic [SPR_W-1:0]   r_spr, n_spr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_target, n_target;
    logic [INTV_W-1:0]  r_interval, n_interval;
    logic [TIME_W-1:0]  r_last, n_last;
    logic [TIME_W-1:0]  r_now, n_now;
    logic               r_pulse, n_pulse;

    logic [TIME_W-1:0]  w_elapsed;
    logic               w_fire;
    logic               w_accel;
    logic               w_decel;
    logic [CNT_W:0]     w_tail;
    logic [RAMP_W-1:0]  w_dist;
    t_div_ctl           w_div_ctl;
    t_div_sts           w_div_sts;
    logic [INTV_W-1:0]  w_quot;

    assign w_elapsed = r_now - r_last;
    assign w_fire    = (r_count < r_target) && (w_elapsed >= TIME_W'(r_interval));
    assign w_accel   = (r_count < CNT_W'(r_ramp));
    assign w_tail    = {1'b0, r_count} + (CNT_W + 1)'(r_ramp);
    assign w_decel   = (w_tail > {1'b0, r_target});

    always_comb begin
        if (w_accel) begin
            w_dist = RAMP_W'(r_ramp - r_count[RAMP_W-1:0]);
        end else begin
            w_dist = RAMP_W'(w_tail - {1'b0, r_target});
        end
    end

    assign w_div_ctl.start = (r_state == S_RAMP) && (w_accel || w_decel);

    stprg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_base  (r_base),
        .i_dist  (w_dist),
        .i_ramp  (r_ramp),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_ramp     = r_ramp;
        n_spr      = r_spr;
        n_count    = r_count;
        n_target   = r_target;
        n_interval = r_interval;
        n_last     = r_last;
        n_now      = r_now;
        n_pulse    = r_pulse;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_START) begin
                        n_target = CNT_W'(r_spr) * CNT_W'(i_revolutions);
                        n_count  = '0;
                        n_pulse  = 1'b0;
                        n_state  = S_OUT;
                    end else begin
                        n_now   = i_now_us;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (w_fire) begin
                    n_pulse = 1'b1;
                    n_last  = r_now;
                    if (r_ramp == '0) begin
                        n_interval = r_base;
                        n_count    = r_count + 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_RAMP;
                    end
                end else begin
                    n_pulse = 1'b0;
                    n_state = S_OUT;
                end
            end
            S_RAMP: begin
                if (w_accel || w_decel) begin
                    n_state = S_WAIT;
                end else begin
                    n_interval = r_base;
                    n_count    = r_count + 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_WAIT: begin
                if (w_div_sts.done) begin
                    n_interval = w_quot;
                    n_count    = r_count + 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_INTERVAL: begin
                    n_base     = i_cfg_data[INTV_W-1:0];
                    n_interval = i_cfg_data[INTV_W-1:0];
                end
                CFG_RAMP_STEPS: begin
                    n_ramp = i_cfg_data[RAMP_W-1:0];
                end
                CFG_STEPS_PER_REV: begin
                    n_spr = i_cfg_data[SPR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_base     <= BASE_INTERVAL_RST;
            r_ramp     <= RAMP_STEPS_RST;
            r_spr      <= STEPS_PER_REV_RST;
            r_count    <= '0;
            r_target   <= '0;
            r_interval <= BASE_INTERVAL_RST;
            r_last     <= '0;
            r_pulse    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_ramp     <= n_ramp;
            r_spr      <= n_spr;
            r_count    <= n_count;
            r_target   <= n_target;
            r_interval <= n_interval;
            r_last     <= n_last;
            r_pulse    <= n_pulse;
        end
        r_now <= n_now;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_step_pulse = r_pulse;
    assign o_moving     = (r_count < r_target);
    assign o_position   = r_count;

    a_count_within_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_target)
        else $error("step count beyond move target");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_WAIT))
        else $error("divider result with no step waiting");

    a_pulse_has_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_step_pulse) |-> (o_position != '0))
        else $error("step reported with zero position");

    a_wait_divider_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> w_div_sts.busy)
        else $error("waiting on an idle divider");

endmodule

// File: tb/sv/stepper_ramp_pulse_generator_test.sv
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_test
// Self-checking bench for the stepper ramp pulse generator. A short table of
// directed requests and register writes runs first. Phases of random moves
// under several register settings follow. Each result is checked against its
// row's expected value where the table gives one, else an in-bench model of
// the step counter, target, interval and last step time. Both handshake sides
// pause at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_test;
    import stprg_pkg::*;

    localparam int          DIR_ROWS     = 29;
    localparam int          PHASES       = 7;
    localparam int unsigned PHASE_REQS   = 86;
    localparam int unsigned SETTLE_CYC   = 32;
    localparam int unsigned PRESS_AFTER  = 150;
    localparam int unsigned PRESS_CYC    = 300;
    localparam int unsigned WDOG_LIMIT   = 2000;
    localparam int unsigned MOVE_TICKS   = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic              pulse;
        logic              moving;
        logic [CNT_W-1:0]  pos;
    } t_step_res;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DAT_W-1:0] data;
        logic                 req;
        logic [TIME_W-1:0]    now;
        logic [REVS_W-1:0]    revs;
        logic                 typed;
        t_step_res            res;
    } t_drive_row;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_stall;
    logic                  i_req_type    = REQ_TICK;
    logic [TIME_W-1:0]     i_now_us      = '0;
    logic [REVS_W-1:0]     i_revolutions = '0;
    logic                  o_valid;
    logic                  i_stall       = 1'b0;
    logic                  o_step_pulse;
    logic                  o_moving;
    logic [CNT_W-1:0]      o_position;

    logic [INTV_W-1:0] r_base = BASE_INTERVAL_RST;
    logic [RAMP_W-1:0] r_ramp = RAMP_STEPS_RST;
    logic [SPR_W-1:0]  r_spr  = STEPS_PER_REV_RST;
    logic [CNT_W-1:0]  m_count  = '0;
    logic [CNT_W-1:0]  m_target = '0;
    logic [INTV_W-1:0] m_intv   = BASE_INTERVAL_RST;
    logic [TIME_W-1:0] m_last   = '0;

    t_step_res   pulse_queue[$];
    t_step_res   want_res;
    int unsigned err_count    = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;
    int unsigned burst_left   = 0;
    int unsigned reqs_sent    = 0;
    int unsigned starts_sent  = 0;
    int unsigned pulses_pred  = 0;
    int unsigned moves_done   = 0;
    int unsigned reg_writes   = 0;
    bit          press_done   = 1'b0;

    t_drive_row drive_tab [DIR_ROWS] = '{
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd0, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_START, 32'd0, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'hFFFF_FFFF, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd0}},
        '{1'b1, CFG_STEPS_PER_REV, 20'h0FFFF, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_START, 32'd0, 16'hFFFF, 1'b1, '{1'b0, 1'b1, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd999, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd1000, 16'd0, 1'b1, '{1'b1, 1'b1, 32'd1}},
        '{1'b1, CFG_UNUSED_IDX, 20'hFFFFF, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b1, CFG_STEPS_PER_REV, 20'd1, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_START, 32'd0, 16'd2, 1'b1, '{1'b0, 1'b1, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'hFFFF_FF00, 16'd0, 1'b1, '{1'b1, 1'b1, 32'd1}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd743, 16'd0, 1'b1, '{1'b0, 1'b1, 32'd1}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd744, 16'd0, 1'b1, '{1'b1, 1'b0, 32'd2}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd5000, 16'd0, 1'b1, '{1'b0, 1'b0, 32'd2}},
        '{1'b1, CFG_BASE_INTERVAL, 20'd0, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_START, 32'd0, 16'd3, 1'b1, '{1'b0, 1'b1, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd744, 16'd0, 1'b1, '{1'b1, 1'b1, 32'd1}},
        '{1'b1, CFG_BASE_INTERVAL, 20'd1000000, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b1, CFG_RAMP_STEPS, 20'hFFFFF, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd1000744, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000743, 16'd0, 1'b0, '0},
        '{1'b1, CFG_RAMP_STEPS, 20'd2, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b1, CFG_BASE_INTERVAL, 20'd8, REQ_TICK, 32'd0, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_START, 32'd0, 16'd5, 1'b1, '{1'b0, 1'b1, 32'd0}},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000751, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000759, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000767, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000775, 16'd0, 1'b0, '0},
        '{1'b0, 2'd0, 20'd0, REQ_TICK, 32'd2000783, 16'd0, 1'b0, '0}
    };

    stepper_ramp_pulse_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_now_us      (i_now_us),
        .i_revolutions (i_revolutions),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_step_pulse  (o_step_pulse),
        .o_moving      (o_moving),
        .o_position    (o_position)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [INTV_W-1:0] ramp_interval(input logic [CNT_W-1:0] c);
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] cc;
        logic [63:0] q;
        b  = 64'(r_base);
        r  = 64'(r_ramp);
        t  = 64'(m_target);
        cc = 64'(c);
        if (r == 0) return r_base;
        if (cc < r) begin
            q = (b * (r - cc)) / r;
            return q[INTV_W-1:0];
        end
        if (cc + r > t) begin
            q = (b * (cc + r - t)) / r;
            return q[INTV_W-1:0];
        end
        return r_base;
    endfunction

    function automatic t_step_res predict_pulse(input logic req, input logic [TIME_W-1:0] now,
                                                input logic [REVS_W-1:0] revs);
        t_step_res         res;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       prod;
        res.pulse = 1'b0;
        if (req == REQ_START) begin
            prod     = 64'(r_spr) * 64'(revs);
            m_target = prod[CNT_W-1:0];
            m_count  = '0;
        end else if (m_count < m_target) begin
            elapsed = now - m_last;
            if (elapsed >= TIME_W'(m_intv)) begin
                m_last    = now;
                res.pulse = 1'b1;
                m_intv    = ramp_interval(m_count);
                m_count   = m_count + 1;
            end
        end
        res.moving = (m_count < m_target);
        res.pos    = m_count;
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned sel;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        if (sel < 55) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [TIME_W-1:0] tick_time();
        int unsigned sel;
        int unsigned span;
        sel  = $urandom_range(0, 99);
        span = int'(m_intv);
        if (sel < 15) return m_last + $urandom_range(0, span);
        if (sel < 30 && span > 0) return m_last + span - 1;
        if (sel < 70) return m_last + span;
        return m_last + span + $urandom_range(1, 50);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at result %0d: %s got 0x%0h expected 0x%0h",
                 results_seen, what, got, want);
        err_count++;
    endtask

    task automatic send_req(input logic req, input logic [TIME_W-1:0] now,
                            input logic [REVS_W-1:0] revs, input logic typed,
                            input t_step_res typed_res);
        t_step_res   pred;
        int unsigned gap;
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_now_us      <= now;
        i_revolutions <= revs;
        do @(posedge i_clk); while (o_stall);
        pred = predict_pulse(req, now, revs);
        pulse_queue.push_back(typed ? typed_res : pred);
        reqs_sent++;
        if (req == REQ_START) starts_sent++;
        if (pred.pulse) pulses_pred++;
        if (pred.pulse && !pred.moving) moves_done++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid, drain pending results, then let the divider finish
    task automatic settle();
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        while (pulse_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_BASE_INTERVAL: begin
                r_base = data[INTV_W-1:0];
                m_intv = data[INTV_W-1:0];
            end
            CFG_RAMP_STEPS:    r_ramp = data[RAMP_W-1:0];
            CFG_STEPS_PER_REV: r_spr  = data[SPR_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic pick_setting(input int phase, output logic [CFG_DAT_W-1:0] base_v,
                                output logic [CFG_DAT_W-1:0] ramp_v,
                                output logic [CFG_DAT_W-1:0] spr_v,
                                output int unsigned max_revs);
        case (phase)
            0: begin
                base_v = CFG_DAT_W'($urandom_range(1, 40));
                ramp_v = CFG_DAT_W'($urandom_range(0, 8));
                spr_v = CFG_DAT_W'($urandom_range(1, 6)); max_revs = 4;
            end
            1: begin
                base_v = 20'd1000000; ramp_v = 20'hFFFFF; spr_v = 20'd1; max_revs = 6;
            end
            2: begin
                base_v = 20'd1; ramp_v = 20'd0; spr_v = 20'h0FFFF; max_revs = 1;
            end
            3: begin
                base_v = CFG_DAT_W'($urandom_range(1, 1000000));
                ramp_v = CFG_DAT_W'($urandom_range(0, 20'hFFFFF));
                spr_v = CFG_DAT_W'($urandom_range(1, 16'hFFFF)); max_revs = 1;
            end
            4: begin
                base_v = CFG_DAT_W'($urandom_range(1, 20));
                ramp_v = CFG_DAT_W'($urandom_range(1, 30));
                spr_v = CFG_DAT_W'($urandom_range(1, 4)); max_revs = 8;
            end
            5: begin
                base_v = 20'd0; ramp_v = CFG_DAT_W'($urandom_range(0, 3));
                spr_v = 20'd3; max_revs = 5;
            end
            default: begin
                base_v = CFG_DAT_W'($urandom_range(2, 100));
                ramp_v = CFG_DAT_W'($urandom_range(1, 5));
                spr_v = CFG_DAT_W'($urandom_range(2, 10)); max_revs = 3;
            end
        endcase
    endtask

    task automatic run_moves(input int unsigned n_reqs, input int unsigned max_revs);
        int unsigned left;
        int unsigned sel;
        int unsigned ticks;
        left = n_reqs;
        while (left > 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                send_req(REQ_TICK, $urandom, 16'($urandom), 1'b0, '0);
                left--;
            end else if (sel < 12) begin
                send_req(REQ_START, $urandom, 16'($urandom), 1'b0, '0);
                left--;
            end else begin
                send_req(REQ_START, $urandom, 16'($urandom_range(0, max_revs)), 1'b0, '0);
                left--;
                ticks = 0;
                while (m_count < m_target && left > 0 && ticks < MOVE_TICKS) begin
                    send_req(REQ_TICK, tick_time(), 16'($urandom), 1'b0, '0);
                    left--;
                    ticks++;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pulse_queue.size() == 0) begin
                report_mismatch("result with nothing pending, position", o_position, '0);
            end else begin
                want_res = pulse_queue.pop_front();
                if (o_step_pulse !== want_res.pulse)
                    report_mismatch("step_pulse", 32'(o_step_pulse), 32'(want_res.pulse));
                if (o_moving !== want_res.moving)
                    report_mismatch("moving", 32'(o_moving), 32'(want_res.moving));
                if (o_position !== want_res.pos)
                    report_mismatch("position", o_position, want_res.pos);
            end
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Watchdog: no request or result moved for %0d cycles", WDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int unsigned sel;
        int unsigned hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!press_done && results_seen >= PRESS_AFTER && i_valid) begin
                i_stall <= 1'b1;
                repeat (PRESS_CYC) @(posedge i_clk);
                press_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 50) hold = 0;
                else if (sel < 90) hold = $urandom_range(1, 3);
                else hold = $urandom_range(8, 40);
                if (hold > 0) begin
                    i_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                end
                i_stall <= 1'b0;
                if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 80)) @(posedge i_clk);
                else repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [CFG_DAT_W-1:0] base_v;
        logic [CFG_DAT_W-1:0] ramp_v;
        logic [CFG_DAT_W-1:0] spr_v;
        int unsigned          max_revs;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (drive_tab[k].is_cfg)
                write_reg(drive_tab[k].idx, drive_tab[k].data);
            else
                send_req(drive_tab[k].req, drive_tab[k].now, drive_tab[k].revs,
                         drive_tab[k].typed, drive_tab[k].res);
        end
        for (int p = 0; p < PHASES; p++) begin
            pick_setting(p, base_v, ramp_v, spr_v, max_revs);
            write_reg(CFG_BASE_INTERVAL, base_v);
            write_reg(CFG_RAMP_STEPS, ramp_v);
            write_reg(CFG_STEPS_PER_REV, spr_v);
            run_moves(PHASE_REQS, max_revs);
        end
        settle();
        $display("Run covered %0d requests (%0d starts), %0d step pulses, %0d moves to target",
                 reqs_sent, starts_sent, pulses_pred, moves_done);
        $display("Register writes: %0d over %0d settings; results checked: %0d",
                 reg_writes, PHASES + 1, results_seen);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/stprg_pkg.sv
rtl/stprg_div.sv
rtl/stepper_ramp_pulse_generator.sv
tb/sv/stepper_ramp_pulse_generator_test.sv
